FILE: rtl/ncc_pkg.sv
// Package for the numeric column counter: types, character constants and the field recognizer.
`default_nettype none

package ncc_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        PH_LEAD = 2'd0,
        PH_SKIP = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_DATA   = 2'd1,
        ST_MALFORMED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RES_GO    = 2'd0,
        RES_END   = 2'd1,
        RES_BAD   = 2'd2,
        RES_CNTGO = 2'd3
    } t_res;

    typedef enum logic [4:0] {
        S_GAP, S_SIGN, S_ZERO, S_INT, S_DOT0, S_FRAC, S_EXP, S_EXPS, S_EXPD,
        S_HX0, S_HXDOT0, S_HXINT, S_HXFRAC, S_HXEXP, S_HXEXPS, S_HXEXPD,
        S_I, S_IN, S_INF, S_INFI, S_INFIN, S_INFINI, S_INFINIT, S_INFINITY,
        S_N, S_NA, S_NAN, S_NANP, S_NANDONE
    } t_num;

    typedef struct packed {
        logic   answer_given;
        t_phase phase;
        t_num   num_state;
    } t_ctl;

    typedef struct packed {
        logic    valid;
        t_status status;
    } t_emit;

    typedef struct packed {
        t_num next;
        t_res res;
    } t_trans;

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[8'd9:8'd13]});
    endfunction

    function automatic logic is_delim(logic [7:0] c);
        return is_space(c) || (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_PIPE);
    endfunction

    function automatic logic is_dig(logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic [7:0] lower(logic [7:0] c);
        return (c inside {["A":"Z"]}) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return is_dig(c) || (lower(c) inside {["a":"f"]});
    endfunction

    function automatic logic is_sign(logic [7:0] c);
        return (c == "+") || (c == "-");
    endfunction

    // One step of the strtod syntax recognizer.
    function automatic t_trans trans(t_num s, logic [7:0] c);
        logic [7:0] l;
        t_trans     t;
        l      = lower(c);
        t.next = s;
        t.res  = RES_GO;
        case (s)
            S_GAP: begin
                if (is_delim(c)) t.next = S_GAP;
                else if (is_sign(c)) t.next = S_SIGN;
                else if (c == "0") t.next = S_ZERO;
                else if (is_dig(c)) t.next = S_INT;
                else if (c == ".") t.next = S_DOT0;
                else if (l == "i") t.next = S_I;
                else if (l == "n") t.next = S_N;
                else t.res = RES_BAD;
            end
            S_SIGN: begin
                if (c == "0") t.next = S_ZERO;
                else if (is_dig(c)) t.next = S_INT;
                else if (c == ".") t.next = S_DOT0;
                else if (l == "i") t.next = S_I;
                else if (l == "n") t.next = S_N;
                else t.res = RES_BAD;
            end
            S_ZERO: begin
                if (is_dig(c)) t.next = S_INT;
                else if (c == ".") t.next = S_FRAC;
                else if (l == "e") t.next = S_EXP;
                else if (l == "x") t.next = S_HX0;
                else t.res = RES_END;
            end
            S_INT: begin
                if (is_dig(c)) t.next = S_INT;
                else if (c == ".") t.next = S_FRAC;
                else if (l == "e") t.next = S_EXP;
                else t.res = RES_END;
            end
            S_DOT0: begin
                if (is_dig(c)) t.next = S_FRAC;
                else t.res = RES_BAD;
            end
            S_FRAC: begin
                if (is_dig(c)) t.next = S_FRAC;
                else if (l == "e") t.next = S_EXP;
                else t.res = RES_END;
            end
            S_EXP: begin
                if (is_dig(c)) t.next = S_EXPD;
                else if (is_sign(c)) t.next = S_EXPS;
                else t.res = RES_BAD;
            end
            S_EXPS: begin
                if (is_dig(c)) t.next = S_EXPD;
                else t.res = RES_BAD;
            end
            S_EXPD: begin
                if (!is_dig(c)) t.res = RES_END;
            end
            S_HX0: begin
                if (is_hex(c)) t.next = S_HXINT;
                else if (c == ".") t.next = S_HXDOT0;
                else t.res = RES_BAD;
            end
            S_HXDOT0: begin
                if (is_hex(c)) t.next = S_HXFRAC;
                else t.res = RES_BAD;
            end
            S_HXINT: begin
                if (is_hex(c)) t.next = S_HXINT;
                else if (c == ".") t.next = S_HXFRAC;
                else if (l == "p") t.next = S_HXEXP;
                else t.res = RES_END;
            end
            S_HXFRAC: begin
                if (is_hex(c)) t.next = S_HXFRAC;
                else if (l == "p") t.next = S_HXEXP;
                else t.res = RES_END;
            end
            S_HXEXP: begin
                if (is_dig(c)) t.next = S_HXEXPD;
                else if (is_sign(c)) t.next = S_HXEXPS;
                else t.res = RES_BAD;
            end
            S_HXEXPS: begin
                if (is_dig(c)) t.next = S_HXEXPD;
                else t.res = RES_BAD;
            end
            S_HXEXPD: begin
                if (!is_dig(c)) t.res = RES_END;
            end
            S_I: begin
                if (l == "n") t.next = S_IN;
                else t.res = RES_BAD;
            end
            S_IN: begin
                if (l == "f") t.next = S_INF;
                else t.res = RES_BAD;
            end
            S_INF: begin
                if (l == "i") t.next = S_INFI;
                else t.res = RES_END;
            end
            S_INFI: begin
                if (l == "n") t.next = S_INFIN;
                else t.res = RES_BAD;
            end
            S_INFIN: begin
                // "inf" followed by "inf": the first field is complete and a new one has begun.
                if (l == "i") t.next = S_INFINI;
                else if (l == "f") begin
                    t.next = S_INF;
                    t.res  = RES_CNTGO;
                end else t.res = RES_BAD;
            end
            S_INFINI: begin
                if (l == "t") t.next = S_INFINIT;
                else t.res = RES_BAD;
            end
            S_INFINIT: begin
                if (l == "y") t.next = S_INFINITY;
                else t.res = RES_BAD;
            end
            S_INFINITY: t.res = RES_END;
            S_N: begin
                if (l == "a") t.next = S_NA;
                else t.res = RES_BAD;
            end
            S_NA: begin
                if (l == "n") t.next = S_NAN;
                else t.res = RES_BAD;
            end
            S_NAN: begin
                if (c == "(") t.next = S_NANP;
                else t.res = RES_END;
            end
            S_NANP: begin
                if (is_dig(c) || (l inside {["a":"z"]}) || (c == "_")) t.next = S_NANP;
                else if (c == ")") t.next = S_NANDONE;
                else t.res = RES_BAD;
            end
            S_NANDONE: t.res = RES_END;
            default: t.res = RES_BAD;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/numeric_column_counter.sv
// Top level of the numeric column counter: input register, line scanner and result register.
//
//  channel  direction  tdata                         tuser
//  s_axis   in         [7:0] text_byte               [0] op (0 byte, 1 end of file)
//  m_axis   out        [COUNT_BITS-1:0] column_count [1:0] status
//
// One byte is accepted per cycle while the input register is not stalled; a registered
// byte then updates the scanner state and the result register together.
// The only loop is the scanner state register, closed through one step of logic.
// The input register stalls only when a pending result meets a full, stalled output.
// Synchronous active-low reset clears the valid flags and the scanner state.
`default_nettype none

module numeric_column_counter #(
    parameter int COUNT_BITS = ncc_pkg::COUNT_BITS_DEF,
    localparam int OUT_W = ((COUNT_BITS + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [7:0]       s_axis_tdata,   // [7:0] text_byte
    input  wire logic             s_axis_tuser,   // [0] op
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic      [OUT_W-1:0] m_axis_tdata,   // [COUNT_BITS-1:0] column_count, zero fill
    output logic      [1:0]       m_axis_tuser    // [1:0] status
);

    logic                   r_in_valid;
    logic                   r_in_op;
    logic [7:0]             r_in_byte;
    ncc_pkg::t_ctl          r_ctl;
    logic [COUNT_BITS-1:0]  r_count;
    logic                   r_out_valid;
    ncc_pkg::t_status       r_out_status;
    logic [COUNT_BITS-1:0]  r_out_count;

    ncc_pkg::t_ctl          n_ctl;
    logic [COUNT_BITS-1:0]  n_count;
    ncc_pkg::t_emit         w_emit;
    logic [COUNT_BITS-1:0]  w_emit_count;
    logic                   w_advance;

    ncc_scan #(
        .COUNT_BITS(COUNT_BITS)
    ) u_scan (
        .i_op        (r_in_op),
        .i_byte      (r_in_byte),
        .i_ctl       (r_ctl),
        .i_count     (r_count),
        .o_ctl       (n_ctl),
        .o_count     (n_count),
        .o_emit      (w_emit),
        .o_emit_count(w_emit_count)
    );

    assign w_advance     = r_in_valid && (!w_emit.valid || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op   <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.answer_given <= 1'b0;
            r_ctl.phase        <= ncc_pkg::PH_LEAD;
            r_ctl.num_state    <= ncc_pkg::S_GAP;
            r_count            <= '0;
        end else if (w_advance) begin
            r_ctl   <= n_ctl;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit.valid) begin
            r_out_status <= w_emit.status;
            r_out_count  <= w_emit_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_count);
    assign m_axis_tuser  = r_out_status;

endmodule

`default_nettype wire

FILE: rtl/ncc_scan.sv
// Per-byte line scanner: next control state, column count and result decision.
`default_nettype none

module ncc_scan #(
    parameter int COUNT_BITS = ncc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                  i_op,
    input  wire logic [7:0]            i_byte,
    input  wire ncc_pkg::t_ctl         i_ctl,
    input  wire logic [COUNT_BITS-1:0] i_count,
    output ncc_pkg::t_ctl              o_ctl,
    output logic      [COUNT_BITS-1:0] o_count,
    output ncc_pkg::t_emit             o_emit,
    output logic      [COUNT_BITS-1:0] o_emit_count
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    ncc_pkg::t_num        w_base;
    ncc_pkg::t_trans      w_t1;
    ncc_pkg::t_trans      w_t2;
    ncc_pkg::t_trans      w_tf;
    logic                 w_feed_bad;
    ncc_pkg::t_num        w_feed_next;
    logic [COUNT_BITS-1:0] w_cnt_base;
    logic [COUNT_BITS-1:0] w_cnt_fed;
    logic [COUNT_BITS-1:0] w_cnt_fin;
    logic                 w_fin_bad;
    logic                 w_line_end;

    // Feeding the current byte: a field that ends here is counted and the byte
    // is then taken again from the gap state.
    always_comb begin
        w_base = (i_ctl.phase == ncc_pkg::PH_DATA) ? i_ctl.num_state : ncc_pkg::S_GAP;
        w_t1   = ncc_pkg::trans(w_base, i_byte);
        w_t2   = ncc_pkg::trans(ncc_pkg::S_GAP, i_byte);
        w_feed_bad  = (w_t1.res == ncc_pkg::RES_BAD) ||
                      ((w_t1.res == ncc_pkg::RES_END) && (w_t2.res == ncc_pkg::RES_BAD));
        w_feed_next = (w_t1.res == ncc_pkg::RES_END) ? w_t2.next : w_t1.next;
        w_cnt_base  = (i_ctl.phase == ncc_pkg::PH_DATA) ? i_count : '0;
        if (((w_t1.res == ncc_pkg::RES_END) || (w_t1.res == ncc_pkg::RES_CNTGO)) &&
            (w_cnt_base != COUNT_MAX)) begin
            w_cnt_fed = w_cnt_base + 1'b1;
        end else begin
            w_cnt_fed = w_cnt_base;
        end

        // Closing the line behaves like a trailing space.
        w_tf = ncc_pkg::trans(i_ctl.num_state, ncc_pkg::CH_SPACE);
        if (((w_tf.res == ncc_pkg::RES_END) || (w_tf.res == ncc_pkg::RES_CNTGO)) &&
            (i_count != COUNT_MAX)) begin
            w_cnt_fin = i_count + 1'b1;
        end else begin
            w_cnt_fin = i_count;
        end
        w_fin_bad  = (w_tf.res == ncc_pkg::RES_BAD) || (w_cnt_fin == '0);
        w_line_end = (i_byte == ncc_pkg::CH_LF) || (i_byte == ncc_pkg::CH_NUL);
    end

    always_comb begin
        o_ctl          = i_ctl;
        o_count        = i_count;
        o_emit.valid   = 1'b0;
        o_emit.status  = ncc_pkg::ST_OK;
        o_emit_count   = '0;
        if (i_op) begin
            if (!i_ctl.answer_given) begin
                o_emit.valid = 1'b1;
                if (i_ctl.phase == ncc_pkg::PH_DATA) begin
                    o_emit.status = w_fin_bad ? ncc_pkg::ST_MALFORMED : ncc_pkg::ST_OK;
                    o_emit_count  = w_fin_bad ? '0 : w_cnt_fin;
                end else begin
                    o_emit.status = ncc_pkg::ST_NO_DATA;
                end
            end
            // End of file always brings back the reset state.
            o_ctl.answer_given = 1'b0;
            o_ctl.phase        = ncc_pkg::PH_LEAD;
            o_ctl.num_state    = ncc_pkg::S_GAP;
            o_count            = '0;
        end else if (!i_ctl.answer_given) begin
            case (i_ctl.phase)
                ncc_pkg::PH_LEAD: begin
                    if (ncc_pkg::is_space(i_byte)) begin
                        o_ctl = i_ctl;
                    end else if ((i_byte == ncc_pkg::CH_HASH) ||
                                 (i_byte == ncc_pkg::CH_NUL)) begin
                        o_ctl.phase = ncc_pkg::PH_SKIP;
                    end else begin
                        o_ctl.phase     = ncc_pkg::PH_DATA;
                        o_ctl.num_state = w_feed_next;
                        o_count         = w_cnt_fed;
                        if (w_feed_bad) begin
                            o_emit.valid       = 1'b1;
                            o_emit.status      = ncc_pkg::ST_MALFORMED;
                            o_ctl.answer_given = 1'b1;
                        end
                    end
                end
                ncc_pkg::PH_SKIP: begin
                    if (i_byte == ncc_pkg::CH_LF) o_ctl.phase = ncc_pkg::PH_LEAD;
                end
                ncc_pkg::PH_DATA: begin
                    if (w_line_end) begin
                        o_emit.valid       = 1'b1;
                        o_emit.status      = w_fin_bad ? ncc_pkg::ST_MALFORMED : ncc_pkg::ST_OK;
                        o_emit_count       = w_fin_bad ? '0 : w_cnt_fin;
                        o_ctl.answer_given = 1'b1;
                    end else begin
                        o_ctl.num_state = w_feed_next;
                        o_count         = w_cnt_fed;
                        if (w_feed_bad) begin
                            o_emit.valid       = 1'b1;
                            o_emit.status      = ncc_pkg::ST_MALFORMED;
                            o_ctl.answer_given = 1'b1;
                        end
                    end
                end
                default: begin
                    o_ctl = i_ctl;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ncc_checker.sv
// Port-level checker for the numeric column counter, bound to the top level.
`default_nettype none

module ncc_checker #(
    parameter int COUNT_BITS = ncc_pkg::COUNT_BITS_DEF,
    localparam int OUT_W = ((COUNT_BITS + 7) / 8) * 8
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata,
    input wire logic [1:0]       m_axis_tuser
);

    // A stalled result keeps its contents until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ncc_pkg::ST_OK) ||
                          (m_axis_tuser == ncc_pkg::ST_NO_DATA) ||
                          (m_axis_tuser == ncc_pkg::ST_MALFORMED))
        else $error("unknown status code");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ncc_pkg::ST_OK) |-> (m_axis_tdata == '0))
        else $error("nonzero count with error status");

    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ncc_pkg::ST_OK) |-> (m_axis_tdata != '0))
        else $error("success status with zero columns");

endmodule

bind numeric_column_counter ncc_checker #(
    .COUNT_BITS(COUNT_BITS)
) u_ncc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
